### design/assert_macros.svh
// Assertion helpers for the ordered list block. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define OLIE_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

`define OLIE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define OLIE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define OLIE_ASSERT(lbl, clk, rstn, expr)

`define OLIE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`define OLIE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### design/olie_pkg.sv
`default_nettype none

package olie_pkg;

    localparam int OP_BITS = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_READ        = 3'd0,
        OP_INSERT      = 3'd1,
        OP_APPEND      = 3'd2,
        OP_ERASE_ONE   = 3'd3,
        OP_ERASE_RANGE = 3'd4,
        OP_CLEAR       = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        RS_OK    = 2'd0,
        RS_INDEX = 2'd1,
        RS_FULL  = 2'd2,
        RS_RANGE = 2'd3
    } result_status_t;

    typedef enum logic [2:0] {
        PLAN_NONE,
        PLAN_READ,
        PLAN_INSERT,
        PLAN_ERASE,
        PLAN_CLEAR
    } plan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_PLACE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic rd_dst;
        logic rd_src;
        logic wr_move;
        logic wr_word;
        logic step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        plan_t plan;
        logic  more;
        logic  out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### design/olie_ctrl.sv
`default_nettype none

module olie_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output olie_pkg::dp_cmd_t      cmd,
    input  wire olie_pkg::dp_stat_t stat
);
    import olie_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (stat.plan)
                    PLAN_READ: begin
                        cmd.rd_dst = 1'b1;
                        state_next = ST_READ;
                    end
                    PLAN_INSERT: begin
                        state_next = stat.more ? ST_MOVE_RD : ST_PLACE;
                    end
                    PLAN_ERASE: begin
                        state_next = stat.more ? ST_MOVE_RD : ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ: begin
                state_next = ST_DONE;
            end
            ST_MOVE_RD: begin
                cmd.rd_src = 1'b1;
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                cmd.wr_move = 1'b1;
                cmd.step    = 1'b1;
                state_next  = ST_DECODE;
            end
            ST_PLACE: begin
                cmd.wr_word = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/olie_dp.sv
`default_nettype none

module olie_dp #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int CW        = 5
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [olie_pkg::OP_BITS-1:0] operation,
    input  wire logic [CW-1:0]                position,
    input  wire logic [CW-1:0]                range_end,
    input  wire logic [WORD_BITS-1:0]         word_in,
    input  wire olie_pkg::dp_cmd_t            cmd,
    output olie_pkg::dp_stat_t                stat,
    input  wire logic                         m_tready,
    output logic                              m_tvalid,
    output logic [WORD_BITS-1:0]              word_out,
    output logic [CW-1:0]                     entry_count,
    output logic                              is_empty,
    output logic [1:0]                        status
);
    import olie_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    plan_t                plan_reg, plan_next;
    result_status_t       status_reg, status_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        dst_reg, dst_next;
    logic [WORD_BITS-1:0] word_reg;
    logic [CW-1:0]        count_reg, count_next;

    logic                 m_valid_reg;
    logic [WORD_BITS-1:0] out_word_reg;
    logic [CW-1:0]        out_count_reg;
    logic                 out_empty_reg;
    logic [1:0]           out_status_reg;

    logic                 full;
    logic [CW:0]          dst_plus_n;
    logic [CW-1:0]        src;
    logic [AW-1:0]        mem_raddr;
    logic                 mem_re;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;

    assign full       = (count_reg == CW'(DEPTH));
    assign dst_plus_n = {1'b0, dst_reg} + {1'b0, n_reg};

    always_comb begin
        plan_next   = PLAN_NONE;
        status_next = RS_OK;
        pos_next    = position;
        n_next      = '0;
        dst_next    = position;
        unique case (op_t'(operation))
            OP_READ: begin
                if (position < count_reg) begin
                    plan_next = PLAN_READ;
                end else begin
                    status_next = RS_INDEX;
                end
            end
            OP_INSERT: begin
                dst_next = count_reg;
                if (full) begin
                    status_next = RS_FULL;
                end else if (position > count_reg) begin
                    status_next = RS_INDEX;
                end else begin
                    plan_next = PLAN_INSERT;
                end
            end
            OP_APPEND: begin
                dst_next = count_reg;
                pos_next = count_reg;
                if (full) begin
                    status_next = RS_FULL;
                end else begin
                    plan_next = PLAN_INSERT;
                end
            end
            OP_ERASE_ONE: begin
                n_next = CW'(1);
                if (position >= count_reg) begin
                    status_next = RS_INDEX;
                end else begin
                    plan_next = PLAN_ERASE;
                end
            end
            OP_ERASE_RANGE: begin
                n_next = range_end - position;
                if (range_end < position) begin
                    status_next = RS_RANGE;
                end else if (range_end > count_reg) begin
                    status_next = RS_INDEX;
                end else if (range_end != position) begin
                    plan_next = PLAN_ERASE;
                end
            end
            OP_CLEAR: begin
                plan_next = PLAN_CLEAR;
            end
            default: begin
                plan_next = PLAN_NONE;
            end
        endcase
    end

    always_comb begin
        stat.plan     = plan_reg;
        stat.out_free = !m_valid_reg || m_tready;
        case (plan_reg)
            PLAN_INSERT: stat.more = (dst_reg > pos_reg);
            PLAN_ERASE:  stat.more = (dst_plus_n < {1'b0, count_reg});
            default:     stat.more = 1'b0;
        endcase
    end

    assign src       = (plan_reg == PLAN_INSERT) ? (dst_reg - CW'(1)) : dst_plus_n[CW-1:0];
    assign mem_re    = cmd.rd_dst || cmd.rd_src;
    assign mem_raddr = cmd.rd_src ? src[AW-1:0] : dst_reg[AW-1:0];
    assign mem_we    = cmd.wr_move || cmd.wr_word;
    assign mem_wdata = cmd.wr_word ? word_reg : rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[dst_reg[AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            plan_reg   <= plan_next;
            status_reg <= status_next;
            pos_reg    <= pos_next;
            n_reg      <= n_next;
            word_reg   <= word_in;
        end
        if (cmd.latch) begin
            dst_reg <= dst_next;
        end else if (cmd.step) begin
            dst_reg <= (plan_reg == PLAN_INSERT) ? (dst_reg - CW'(1)) : (dst_reg + CW'(1));
        end
    end

    always_comb begin
        case (plan_reg)
            PLAN_INSERT: count_next = count_reg + CW'(1);
            PLAN_ERASE:  count_next = count_reg - n_reg;
            PLAN_CLEAR:  count_next = '0;
            default:     count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_word_reg   <= (plan_reg == PLAN_READ) ? rdata_reg : '0;
            out_count_reg  <= count_next;
            out_empty_reg  <= (count_next == '0);
            out_status_reg <= status_reg;
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign word_out    = out_word_reg;
    assign entry_count = out_count_reg;
    assign is_empty    = out_empty_reg;
    assign status      = out_status_reg;

endmodule

`default_nettype wire

### design/ordered_list_insert_erase.sv
// Ordered word list of up to DEPTH words kept in a single-port memory, one request at a time.
// After acceptance a read passes through decode, read and done; an insert or append repeats
// move-read, move-write and decode for each stored word that moves, then places the word,
// and an erase does the moves alone. Clear and rejected requests go from decode to done. Each
// moved word needs one read, one write and one bound check on the memory port. A result waits
// in the output register while the next request is already being accepted and worked on.
`default_nettype none

`include "assert_macros.svh"

module ordered_list_insert_erase #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int S_TDATA_W = ((2 * CW + WORD_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((WORD_BITS + CW + 3 + 7) / 8) * 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // position, range_end, word_in
    input  wire logic [S_TDATA_W-1:0]         s_tdata,
    // operation
    input  wire logic [olie_pkg::OP_BITS-1:0] s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // word_out, entry_count, is_empty, status
    output logic [M_TDATA_W-1:0]              m_tdata
);
    import olie_pkg::*;

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic [WORD_BITS-1:0] word_out;
    logic [CW-1:0]        entry_count;
    logic                 is_empty;
    logic [1:0]           status;

    olie_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    olie_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .CW        (CW)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .operation   (s_tuser),
        .position    (s_tdata[CW-1:0]),
        .range_end   (s_tdata[2*CW-1:CW]),
        .word_in     (s_tdata[2*CW+WORD_BITS-1:2*CW]),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .word_out    (word_out),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .status      (status)
    );

    assign m_tdata = M_TDATA_W'({status, is_empty, entry_count, word_out});

    `OLIE_ASSERT_IMPL(a_count_bound, aclk, aresetn, m_tvalid, entry_count <= CW'(DEPTH))
    `OLIE_ASSERT_IMPL(a_empty_flag, aclk, aresetn, m_tvalid, is_empty == (entry_count == '0))
    `OLIE_ASSERT_IMPL(a_word_only_ok, aclk, aresetn, m_tvalid && (word_out != '0), status == RS_OK)
    `OLIE_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire

### verif/ordered_list_checker.sv
`timescale 1ns / 100ps

module ordered_list_checker #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int S_W       = 48,
    parameter int M_W       = 40
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [S_W-1:0] s_tdata,
    input  logic [2:0]     s_tuser,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [M_W-1:0] m_tdata,
    output int             fail_count,
    output int             pending,
    output int             list_len
);
    import olie_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [CW-1:0]        count;
        logic                 empty;
        result_status_t       status;
    } list_result_t;

    logic [WORD_BITS-1:0] stored_q[$];
    list_result_t         expected_q[$];
    int                   fails = 0;

    assign fail_count = fails;

    function automatic list_result_t apply_request(input logic [2:0] code,
                                                   input logic [CW-1:0] pos,
                                                   input logic [CW-1:0] last,
                                                   input logic [WORD_BITS-1:0] word);
        list_result_t r;
        r = '0;
        r.status = RS_OK;
        case (op_t'(code))
            OP_READ: begin
                if (pos < stored_q.size()) r.word = stored_q[pos];
                else r.status = RS_INDEX;
            end
            OP_INSERT: begin
                if (stored_q.size() >= DEPTH) r.status = RS_FULL;
                else if (pos > stored_q.size()) r.status = RS_INDEX;
                else stored_q.insert(pos, word);
            end
            OP_APPEND: begin
                if (stored_q.size() >= DEPTH) r.status = RS_FULL;
                else stored_q.push_back(word);
            end
            OP_ERASE_ONE: begin
                if (pos >= stored_q.size()) r.status = RS_INDEX;
                else stored_q.delete(pos);
            end
            OP_ERASE_RANGE: begin
                if (last < pos) r.status = RS_RANGE;
                else if (last > stored_q.size()) r.status = RS_INDEX;
                else repeat (last - pos) stored_q.delete(pos);
            end
            OP_CLEAR: begin
                stored_q.delete();
            end
            default: begin
            end
        endcase
        r.count = CW'(stored_q.size());
        r.empty = (stored_q.size() == 0);
        return r;
    endfunction

    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (!aresetn) begin
            stored_q.delete();
            expected_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(apply_request(s_tuser, s_tdata[CW-1:0],
                                                   s_tdata[2*CW-1:CW],
                                                   s_tdata[2*CW+WORD_BITS-1:2*CW]));
            end
            if (m_tvalid && m_tready) begin
                got.word   = m_tdata[WORD_BITS-1:0];
                got.count  = m_tdata[WORD_BITS+CW-1:WORD_BITS];
                got.empty  = m_tdata[WORD_BITS+CW];
                got.status = result_status_t'(m_tdata[WORD_BITS+CW+2 -: 2]);
                if (expected_q.size() == 0) begin
                    $error("result arrived with no request outstanding: %h", m_tdata);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.word !== want.word) begin
                        $error("word_out: expected %h, got %h", want.word, got.word);
                        fails++;
                    end
                    if (got.count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count, got.count);
                        fails++;
                    end
                    if (got.empty !== want.empty) begin
                        $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                end
            end
        end
        pending  = expected_q.size();
        list_len = stored_q.size();
    end

endmodule

### verif/ordered_list_insert_erase_tb.sv
`timescale 1ns / 100ps

module ordered_list_insert_erase_tb;
    import olie_pkg::*;

    localparam int DEPTH       = 16;
    localparam int WORD_BITS   = 32;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int S_W         = ((2 * CW + WORD_BITS + 7) / 8) * 8;
    localparam int M_W         = ((WORD_BITS + CW + 3 + 7) / 8) * 8;
    localparam int ITEMS       = 700;
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;
    logic [2:0]     s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [M_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int list_len;
    int quiet_cycles = 0;
    int hold_asked   = 0;
    int burst_left   = 0;
    int steady_left  = 0;

    ordered_list_insert_erase #(
        .DEPTH    (DEPTH),
        .WORD_BITS(WORD_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    ordered_list_checker #(
        .DEPTH    (DEPTH),
        .WORD_BITS(WORD_BITS),
        .S_W      (S_W),
        .M_W      (M_W)
    ) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending),
        .list_len  (list_len)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ordered_list_insert_erase_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The receiver switches between stall patterns and honors long hold-off requests.
    int hold_seen = 0;
    int hold_left = 0;
    int mode      = 0;
    int mode_left = 0;
    int phase     = 0;

    always @(posedge aclk) begin
        phase++;
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= (phase % 4 == 0);
            endcase
        end
    end

    task automatic issue(input logic [2:0] op, input logic [CW-1:0] pos,
                         input logic [CW-1:0] last, input logic [WORD_BITS-1:0] word);
        int gap;
        s_tuser  <= op;
        s_tdata  <= {{(S_W - 2 * CW - WORD_BITS){1'b0}}, word, last, pos};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (steady_left > 0) begin
            steady_left--;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(1, 10);
            burst_left = $urandom_range(0, 20);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [2:0]           op;
        logic [CW-1:0]        pos;
        logic [CW-1:0]        last;
        logic [WORD_BITS-1:0] word;
        int                   len;
        int                   roll;
        bit                   grow;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests, starting from an empty list and filling it to DEPTH.
        issue(OP_READ, 0, 0, 32'h1234_5678);
        issue(OP_ERASE_ONE, 0, 0, '0);
        issue(OP_ERASE_RANGE, 0, 0, '0);
        issue(OP_ERASE_RANGE, 1, 0, '0);
        issue(OP_INSERT, 1, 0, 32'hDEAD_BEEF);
        issue(OP_INSERT, 0, 31, '1);
        issue(OP_INSERT, 0, 0, '0);
        issue(OP_INSERT, 1, 0, 32'hA5A5_A5A5);
        issue(OP_READ, 1, 0, '0);
        for (int i = 0; i < 13; i++) issue(OP_APPEND, 0, 0, pick_word());
        issue(OP_INSERT, 16, 0, 32'h5A5A_5A5A);
        issue(OP_APPEND, 31, 31, '1);
        issue(OP_READ, 15, 0, '0);
        issue(OP_READ, 16, 0, '0);
        issue(OP_ERASE_RANGE, 4, 17, '0);
        issue(OP_ERASE_RANGE, 3, 16, '0);
        issue(OP_ERASE_ONE, 0, 0, '0);
        issue(OP_SPARE_LO, 0, 0, '1);
        issue(OP_SPARE_HI, 31, 31, '1);
        issue(OP_CLEAR, 0, 0, '0);
        drain();

        for (int n = 0; n < ITEMS; n++) begin
            grow = ((n / 80) % 2 == 0);
            if (n == 250) begin
                hold_asked++;
                steady_left = 30;
            end
            if (n == 500) drain();
            len  = list_len;
            word = pick_word();
            pos  = '0;
            last = '0;
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                op   = 3'($urandom());
                pos  = CW'($urandom());
                last = CW'($urandom());
            end else if (roll < 28) begin
                op  = OP_READ;
                pos = CW'((len > 0 && $urandom_range(0, 7) != 0) ?
                          $urandom_range(0, len - 1) : $urandom_range(len, DEPTH));
            end else if (roll < (grow ? 55 : 40)) begin
                op  = OP_INSERT;
                pos = CW'(($urandom_range(0, 7) != 0) ?
                          $urandom_range(0, len) : $urandom_range(len, DEPTH));
            end else if (roll < (grow ? 75 : 50)) begin
                op = OP_APPEND;
            end else if (roll < (grow ? 85 : 75)) begin
                op  = OP_ERASE_ONE;
                pos = CW'((len > 0 && $urandom_range(0, 7) != 0) ?
                          $urandom_range(0, len - 1) : $urandom_range(len, DEPTH));
            end else if (roll < 95) begin
                op = OP_ERASE_RANGE;
                if ($urandom_range(0, 5) != 0) begin
                    last = CW'($urandom_range(0, len));
                    pos  = CW'($urandom_range(0, last));
                end else begin
                    pos  = CW'($urandom_range(0, DEPTH));
                    last = CW'($urandom_range(0, DEPTH));
                end
            end else if (roll < 97) begin
                op = OP_CLEAR;
            end else begin
                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end
            issue(op, pos, last, word);
        end

        drain();
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("ordered_list_insert_erase_tb OK");
        end else begin
            $display("ordered_list_insert_erase_tb NOT OK");
        end
        $finish;
    end

endmodule
